// File: rtl/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants of the DAG topological scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_DEPS  = 8;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int TOT_W     = NODE_W + 1;
  localparam int CNT_W     = 4;
  localparam int WAVE_W    = 6;
  localparam int ROW_W     = CNT_W + MAX_DEPS * NODE_W;
  localparam int FIFO_W    = NODE_W + WAVE_W;

  typedef struct packed {
    logic [CNT_W-1:0]  dep_count;
    logic [NODE_W-1:0] dep_0;
    logic [NODE_W-1:0] dep_1;
    logic [NODE_W-1:0] dep_2;
    logic [NODE_W-1:0] dep_3;
    logic [NODE_W-1:0] dep_4;
    logic [NODE_W-1:0] dep_5;
    logic [NODE_W-1:0] dep_6;
    logic [NODE_W-1:0] dep_7;
    logic              final_node;
  } dts_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [WAVE_W-1:0] wave;
    logic              carries_node;
    logic              end_of_run;
    logic              incomplete;
  } dts_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // store the incoming node
    logic init_sweep;  // copy counts into pending degrees, queue roots
    logic scan_sweep;  // release dependants of the current node
    logic pop_take;    // latch the queue head as current node
    logic emit_node;
    logic emit_status;
    logic clear_run;
  } dts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_done;
    logic fifo_empty;
    logic all_done;
    logic out_free;
  } dts_stat_t;

endpackage

`default_nettype wire

// File: rtl/dts_ram.sv
// ----------------------------------------------------------------------------
// dts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/dts_ctrl.sv
// ----------------------------------------------------------------------------
// dts_ctrl
// Sequencer: load phase, then init sweep and pop / scan / emit per node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dts_ctrl
  import dts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      final_node,
  output logic           in_stall,
  input  wire dts_stat_t stat,
  output dts_cmd_t       cmd
);

  typedef enum logic [6:0] {
    ST_LOAD   = 7'b0000001,
    ST_INIT   = 7'b0000010,
    ST_POP    = 7'b0000100,
    ST_POPW   = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_EMIT   = 7'b0100000,
    ST_STATUS = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid && final_node) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init_sweep = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = stat.fifo_empty ? ST_STATUS : ST_POP;
        end
      end
      ST_POP: begin
        state_nxt = ST_POPW;
      end
      ST_POPW: begin
        cmd.pop_take = 1'b1;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_sweep = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_node = 1'b1;
          if (!stat.fifo_empty) begin
            state_nxt = ST_POP;
          end else if (stat.all_done) begin
            cmd.clear_run = 1'b1;
            state_nxt     = ST_LOAD;
          end else begin
            state_nxt = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          cmd.clear_run   = 1'b1;
          state_nxt       = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dts_datapath.sv
// ----------------------------------------------------------------------------
// dts_datapath
// Dependency rows, pending degrees, ready queue, sweep pipe and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dts_datapath
  import dts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dts_in_t  in_data,
  input  wire dts_cmd_t cmd,
  output dts_stat_t     stat,
  output logic          out_valid,
  input  wire logic     out_stall,
  output dts_out_t      out_data
);

  logic [TOT_W-1:0]  node_total_r, node_total_nxt;
  logic [TOT_W-1:0]  exec_r, exec_nxt;
  logic [TOT_W-1:0]  head_r, head_nxt;
  logic [TOT_W-1:0]  tail_r, tail_nxt;
  logic [TOT_W-1:0]  idx_r, idx_nxt;
  logic              p_valid_r;
  logic [NODE_W-1:0] p_idx_r;
  logic [NODE_W-1:0] cur_r;
  logic [WAVE_W-1:0] wave_r;
  logic              out_valid_r, out_valid_nxt;
  dts_out_t          out_data_r, out_data_nxt;

  // load side
  logic [CNT_W-1:0]                   cnt_sat;
  logic [MAX_DEPS-1:0][NODE_W-1:0]    deps_in;
  logic                               row_we;
  logic [ROW_W-1:0]                   row_wdata;
  logic [ROW_W-1:0]                   row_rdata;

  // sweep side
  logic                               sweep_on;
  logic                               issue;
  logic [CNT_W-1:0]                   rd_cnt;
  logic [MAX_DEPS-1:0][NODE_W-1:0]    rd_deps;
  logic [CNT_W-1:0]                   hits;
  logic [CNT_W-1:0]                   pend_rdata;
  logic                               pend_we;
  logic [CNT_W-1:0]                   pend_wdata;
  logic                               push;
  logic [WAVE_W-1:0]                  push_wave;
  logic [FIFO_W-1:0]                  fifo_rdata;

  assign cnt_sat = (in_data.dep_count > CNT_W'(MAX_DEPS)) ? CNT_W'(MAX_DEPS)
                                                          : in_data.dep_count;
  assign deps_in[0] = in_data.dep_0;
  assign deps_in[1] = in_data.dep_1;
  assign deps_in[2] = in_data.dep_2;
  assign deps_in[3] = in_data.dep_3;
  assign deps_in[4] = in_data.dep_4;
  assign deps_in[5] = in_data.dep_5;
  assign deps_in[6] = in_data.dep_6;
  assign deps_in[7] = in_data.dep_7;

  // nodes beyond capacity are dropped
  assign row_we    = cmd.load && (node_total_r < TOT_W'(MAX_NODES));
  assign row_wdata = {cnt_sat, deps_in};

  assign sweep_on = cmd.init_sweep | cmd.scan_sweep;
  assign issue    = sweep_on && (idx_r < node_total_r);

  dts_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_dep_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (node_total_r[NODE_W-1:0]),
    .wdata (row_wdata),
    .raddr (idx_r[NODE_W-1:0]),
    .rdata (row_rdata)
  );

  dts_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (p_idx_r),
    .wdata (pend_wdata),
    .raddr (idx_r[NODE_W-1:0]),
    .rdata (pend_rdata)
  );

  dts_ram #(.WIDTH(FIFO_W), .DEPTH(MAX_NODES)) u_fifo_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail_r[NODE_W-1:0]),
    .wdata ({p_idx_r, push_wave}),
    .raddr (head_r[NODE_W-1:0]),
    .rdata (fifo_rdata)
  );

  assign rd_cnt  = row_rdata[ROW_W-1 -: CNT_W];
  assign rd_deps = row_rdata[MAX_DEPS*NODE_W-1:0];

  // occurrences of the current node among the valid dependency slots
  always_comb begin
    hits = '0;
    for (int j = 0; j < MAX_DEPS; j++) begin
      if ((CNT_W'(j) < rd_cnt) && (rd_deps[j] == cur_r)) begin
        hits = hits + CNT_W'(1);
      end
    end
  end

  always_comb begin
    pend_we    = 1'b0;
    pend_wdata = rd_cnt;
    push       = 1'b0;
    push_wave  = '0;
    if (p_valid_r && cmd.init_sweep) begin
      pend_we = 1'b1;
      push    = (rd_cnt == '0);
    end else if (p_valid_r && cmd.scan_sweep && (pend_rdata != '0) && (hits != '0)) begin
      pend_we    = 1'b1;
      pend_wdata = (hits >= pend_rdata) ? '0 : (pend_rdata - hits);
      push       = (hits >= pend_rdata);
      push_wave  = wave_r + WAVE_W'(1);
    end
  end

  assign stat.sweep_done = !issue && !p_valid_r;
  assign stat.fifo_empty = (head_r == tail_r);
  assign stat.all_done   = (exec_r == node_total_r);
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    node_total_nxt = node_total_r;
    exec_nxt       = exec_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    idx_nxt        = sweep_on ? idx_r : '0;
    if (row_we) begin
      node_total_nxt = node_total_r + TOT_W'(1);
    end
    if (issue) begin
      idx_nxt = idx_r + TOT_W'(1);
    end
    if (push) begin
      tail_nxt = tail_r + TOT_W'(1);
    end
    if (cmd.pop_take) begin
      head_nxt = head_r + TOT_W'(1);
      exec_nxt = exec_r + TOT_W'(1);
    end
    if (cmd.clear_run) begin
      node_total_nxt = '0;
      exec_nxt       = '0;
      head_nxt       = '0;
      tail_nxt       = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cmd.emit_node) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.node_index   = cur_r;
      out_data_nxt.wave         = wave_r;
      out_data_nxt.carries_node = 1'b1;
      out_data_nxt.end_of_run   = stat.fifo_empty && stat.all_done;
      out_data_nxt.incomplete   = 1'b0;
    end else if (cmd.emit_status) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.node_index   = '0;
      out_data_nxt.wave         = '0;
      out_data_nxt.carries_node = 1'b0;
      out_data_nxt.end_of_run   = 1'b1;
      out_data_nxt.incomplete   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_total_r <= '0;
      exec_r       <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      idx_r        <= '0;
      p_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      node_total_r <= node_total_nxt;
      exec_r       <= exec_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      idx_r        <= idx_nxt;
      p_valid_r    <= issue;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r    <= idx_r[NODE_W-1:0];
    out_data_r <= out_data_nxt;
    if (cmd.pop_take) begin
      cur_r  <= fifo_rdata[FIFO_W-1 -: NODE_W];
      wave_r <= fifo_rdata[WAVE_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // each node is queued at most once per run
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= node_total_r)
    else $error("ready queue holds more entries than loaded nodes");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("ready queue popped past its tail");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_take |-> (head_r != tail_r))
    else $error("pop from an empty ready queue");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_node || cmd.emit_status) |-> stat.out_free)
    else $error("result register overwritten while still held");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_run |=> (node_total_r == '0) && (tail_r == '0))
    else $error("run state not cleared at end of run");

endmodule

`default_nettype wire

// File: rtl/dag_topological_scheduler_top.sv
// ----------------------------------------------------------------------------
// dag_topological_scheduler_top
// Kahn topological scheduler: loads graph nodes, then emits execution order.
// ----------------------------------------------------------------------------
// Nodes are taken one per cycle and numbered in arrival order; the node with
// final_node set starts the run and in_stall stays high until the run's last
// result has been handed to the result register. The run first sweeps the
// dependency row memory once to seed the ready queue, then sweeps it again
// for every node taken from the queue, one node per cycle. Each result
// carries its wave; an incomplete run ends with a status request that has
// carries_node low and incomplete high.
`timescale 1ns / 1ps
`default_nettype none

module dag_topological_scheduler_top
  import dts_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire dts_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output dts_out_t     out_data
);

  dts_cmd_t  cmd;
  dts_stat_t stat;

  dts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .final_node (in_data.final_node),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  dts_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: dv/dag_topological_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// dag_topological_scheduler_top_tb
// Self-checking bench for the Kahn topological scheduler.
// ----------------------------------------------------------------------------
// A short table of hand-built graphs covers lone roots, self and cyclic
// dependencies, saturated and repeated dependency lists, unloaded and forward
// dependencies. Random graphs follow: mostly well-formed DAGs, some with stray
// dependencies, and one deep chain that overflows the node store. Every
// accepted request feeds a behavioural scheduler whose execution order is
// compared field by field with the result channel.
`timescale 1ns / 1ps

module dag_topological_scheduler_top_tb;
  import dts_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 185;

  localparam dts_out_t LONE_ROOT = '{node_index: 6'd0, wave: 6'd0, carries_node: 1'b1,
                                     end_of_run: 1'b1, incomplete: 1'b0};
  localparam dts_out_t STUCK_RUN = '{node_index: 6'd0, wave: 6'd0, carries_node: 1'b0,
                                     end_of_run: 1'b1, incomplete: 1'b1};

  typedef enum int {SHAPE_CLEAN, SHAPE_NOISY, SHAPE_CHAIN} node_shape_t;

  typedef struct {
    dts_in_t  item;
    bit       typed;
    dts_out_t want;
  } plan_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  dts_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  dts_out_t out_data;

  // scheduler mirror
  logic [NODE_W-1:0] graph_dep [MAX_NODES][MAX_DEPS];
  int                graph_cnt [MAX_NODES];
  int                graph_nodes = 0;
  dts_out_t          run_order [$];
  dts_out_t          exec_order_q [$];

  int unsigned cycle_no   = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left  = 0;
  int unsigned rx_gap     = 0;
  bit          calm       = 1'b0;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;

  plan_row_t plan [15];

  dag_topological_scheduler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  function automatic bit idle_ok();
    return !calm && ((cycle_no / 32) % 4 != 0);
  endfunction

  function automatic dts_in_t node_item(int cnt, int d0, int d1, int d2, int d3, int d4,
                                        int d5, int d6, int d7, bit fin);
    return '{CNT_W'(cnt), NODE_W'(d0), NODE_W'(d1), NODE_W'(d2), NODE_W'(d3),
             NODE_W'(d4), NODE_W'(d5), NODE_W'(d6), NODE_W'(d7), fin};
  endfunction

  // Store the node; on the last node run Kahn's algorithm into run_order.
  function automatic void schedule_node(dts_in_t item);
    int                cnt;
    int                n;
    int                head;
    int                tail;
    int                executed;
    int                pend  [MAX_NODES];
    logic [NODE_W-1:0] ready [MAX_NODES];
    logic [WAVE_W-1:0] lvl   [MAX_NODES];
    logic [NODE_W-1:0] deps  [MAX_DEPS];
    logic [NODE_W-1:0] cur;
    dts_out_t          last;
    dts_out_t          entry;
    run_order.delete();
    deps = '{item.dep_0, item.dep_1, item.dep_2, item.dep_3,
             item.dep_4, item.dep_5, item.dep_6, item.dep_7};
    cnt = int'(item.dep_count);
    if (cnt > MAX_DEPS) cnt = MAX_DEPS;
    // nodes beyond the store are dropped, but a dropped final still starts the run
    if (graph_nodes < MAX_NODES) begin
      for (int j = 0; j < MAX_DEPS; j++) graph_dep[graph_nodes][j] = deps[j];
      graph_cnt[graph_nodes] = cnt;
      graph_nodes++;
    end
    if (!item.final_node) return;
    n = graph_nodes;
    head = 0;
    tail = 0;
    executed = 0;
    for (int i = 0; i < n; i++) begin
      pend[i] = graph_cnt[i];
      if (pend[i] == 0) begin
        ready[tail] = NODE_W'(i);
        lvl[i] = '0;
        tail++;
      end
    end
    while (head < tail) begin
      cur = ready[head];
      head++;
      executed++;
      entry = '{node_index: cur, wave: lvl[cur], carries_node: 1'b1,
                end_of_run: 1'b0, incomplete: 1'b0};
      run_order.insert(run_order.size(), entry);
      // each occurrence of cur in a list releases one count
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < graph_cnt[i]; j++) begin
          if (graph_dep[i][j] == cur && pend[i] > 0) begin
            pend[i]--;
            if (pend[i] == 0) begin
              ready[tail] = NODE_W'(i);
              lvl[i] = lvl[cur] + 1'b1;
              tail++;
            end
          end
        end
      end
    end
    if (executed != n) begin
      run_order.insert(run_order.size(), STUCK_RUN);
    end else begin
      last = run_order.pop_back();
      last.end_of_run = 1'b1;
      run_order.insert(run_order.size(), last);
    end
    graph_nodes = 0;
  endfunction

  function automatic dts_in_t make_node(int idx, int size, node_shape_t shape);
    logic [NODE_W-1:0] d [MAX_DEPS];
    int                cnt;
    for (int j = 0; j < MAX_DEPS; j++) d[j] = NODE_W'($urandom_range(0, 63));
    case (shape)
      SHAPE_NOISY: begin
        cnt = $urandom_range(0, 15);
        for (int j = 0; j < MAX_DEPS; j++)
          if ($urandom_range(0, 1) == 1) d[j] = NODE_W'($urandom_range(0, size - 1));
      end
      SHAPE_CHAIN: begin
        cnt = (idx == 0) ? 0 : (($urandom_range(0, 7) == 0) ? 2 : 1);
        if (idx > 0) begin
          d[0] = NODE_W'(idx - 1);
          d[1] = NODE_W'($urandom_range(0, idx - 1));
        end
      end
      default: begin
        cnt = 0;
        if (idx > 0) begin
          cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 2);
          for (int j = 0; j < cnt; j++) d[j] = NODE_W'($urandom_range(0, idx - 1));
        end
      end
    endcase
    return '{CNT_W'(cnt), d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7], idx == size - 1};
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= 200)
      $display("mismatch at cycle %0d: %0s got %0d want %0d", cycle_no, what, got, want);
  endtask

  task automatic offer(input dts_in_t item, input bit typed, input dts_out_t want);
    if (idle_ok() && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_node(item);
    if (typed) exec_order_q.insert(exec_order_q.size(), want);
    else foreach (run_order[k]) exec_order_q.insert(exec_order_q.size(), run_order[k]);
  endtask

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side back-pressure, with one long hold-off to fill the block
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap    <= rx_gap - 1;
      out_stall <= 1'b1;
    end else if (idle_ok() && $urandom_range(0, 5) == 0) begin
      rx_gap    <= $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    dts_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exec_order_q.size() == 0) begin
        report_mismatch("unexpected request, node_index", out_data.node_index, 0);
      end else begin
        want = exec_order_q.pop_front();
        if (out_data.node_index !== want.node_index)
          report_mismatch("node_index", out_data.node_index, want.node_index);
        if (out_data.wave !== want.wave)
          report_mismatch("wave", out_data.wave, want.wave);
        if (out_data.carries_node !== want.carries_node)
          report_mismatch("carries_node", out_data.carries_node, want.carries_node);
        if (out_data.end_of_run !== want.end_of_run)
          report_mismatch("end_of_run", out_data.end_of_run, want.end_of_run);
        if (out_data.incomplete !== want.incomplete)
          report_mismatch("incomplete", out_data.incomplete, want.incomplete);
      end
    end
  end

  initial begin
    int          sent;
    int          gsize;
    int          g;
    int          mix;
    node_shape_t shape;
    plan = '{
      // lone root
      '{node_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1, LONE_ROOT},
      // node waiting on itself
      '{node_item(1, 0, 63, 63, 63, 63, 63, 63, 63, 1'b1), 1'b1, STUCK_RUN},
      // oversized count, same dependency eight times
      '{node_item(0, 63, 63, 63, 63, 63, 63, 63, 63, 1'b0), 1'b0, '0},
      '{node_item(15, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b0, '0},
      // dependency on a node never loaded
      '{node_item(1, 63, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, '0},
      '{node_item(0, 42, 21, 42, 21, 42, 21, 42, 21, 1'b1), 1'b0, '0},
      // two-node cycle, nothing ever ready
      '{node_item(1, 1, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, '0},
      '{node_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1, STUCK_RUN},
      // full lists with repeats over several waves
      '{node_item(0, 21, 42, 21, 42, 21, 42, 21, 42, 1'b0), 1'b0, '0},
      '{node_item(0, 63, 0, 63, 0, 63, 0, 63, 0, 1'b0), 1'b0, '0},
      '{node_item(8, 0, 1, 0, 1, 0, 1, 0, 1, 1'b0), 1'b0, '0},
      '{node_item(9, 2, 0, 1, 2, 0, 1, 2, 0, 1'b0), 1'b0, '0},
      '{node_item(3, 3, 3, 1, 63, 63, 63, 63, 63, 1'b1), 1'b0, '0},
      // forward dependency on a later node
      '{node_item(1, 1, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, '0},
      '{node_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b0, '0}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // the cycle graph's first node is typed but has nothing to check
    foreach (plan[r]) offer(plan[r].item, plan[r].typed && plan[r].item.final_node,
                            plan[r].want);

    hold_req <= 1'b1;
    sent = 0;
    g = 0;
    while (sent < RANDOM_ITEMS) begin
      gsize = (g == 1) ? MAX_NODES + 2 : $urandom_range(1, 10);
      mix = $urandom_range(0, 19);
      for (int i = 0; i < gsize; i++) begin
        if (g == 1) shape = (i < MAX_NODES) ? SHAPE_CHAIN : SHAPE_NOISY;
        else if (mix < 3 || (mix < 8 && $urandom_range(0, 5) == 0)) shape = SHAPE_NOISY;
        else shape = SHAPE_CLEAN;
        offer(make_node(i, gsize, shape), 1'b0, '0);
        sent++;
      end
      if (sent >= RANDOM_ITEMS - 40) calm <= 1'b1;
      g++;
    end
    in_valid <= 1'b0;

    while (exec_order_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
